### design/adsr_pkg.sv
// ----------------------------------------------------------------------------
// ADSR envelope gain package
// Shared codes, fixed-point constants and types for the envelope block.
// ----------------------------------------------------------------------------
package adsr_pkg;

  // Gains are unsigned Q1.15; 1.0 is the top bit of a 16-bit word.
  localparam int GAIN_BITS = 16;
  localparam int FRAC_BITS = 15;
  localparam logic [GAIN_BITS-1:0] GAIN_ONE = 16'h8000;
  localparam int ROUND_HALF = 16384;

  // Default stage length: one millisecond at 44.1 kHz.
  localparam int DEFAULT_LEN = 1 * 44100 / 1000;

  // One multiplier or quotient bit per cycle, one per gain bit.
  localparam int STEP_BITS = $clog2(GAIN_BITS);

  // Commands carried with each input word.
  typedef enum logic [1:0] {
    CMD_SAMPLE   = 2'd0,
    CMD_NOTE_ON  = 2'd1,
    CMD_NOTE_OFF = 2'd2
  } cmd_e;

  // Configuration register indexes.
  typedef enum logic [1:0] {
    REG_ATTACK_LEN  = 2'd0,
    REG_DECAY_LEN   = 2'd1,
    REG_SUSTAIN_LVL = 2'd2,
    REG_RELEASE_LEN = 2'd3
  } reg_e;

  // Envelope stages as reported on the output.
  typedef enum logic [1:0] {
    STAGE_ATTACK  = 2'd0,
    STAGE_DECAY   = 2'd1,
    STAGE_SUSTAIN = 2'd2,
    STAGE_RELEASE = 2'd3
  } stage_e;

  // Sequencer states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_NORM,
    ST_DIV,
    ST_FIN
  } state_e;

  // What the current multiply or divide pass computes.
  typedef enum logic [1:0] {
    PASS_GAIN,
    PASS_REL,
    PASS_SMP
  } pass_e;

endpackage

### design/adsr_envelope_gain.sv
// ----------------------------------------------------------------------------
// ADSR envelope gain
// Linear attack/decay/sustain/release envelope applied to a sample stream,
// built around a bit-serial shift-add multiplier and restoring divider.
// ----------------------------------------------------------------------------
//
//  Channel  | Signals                                   | Direction
//  ---------+-------------------------------------------+----------
//  input    | in_valid/in_ready, cmd, audio_in,         | in
//           | start_position                            |
//  output   | out_valid/out_ready, audio_out, stage,    | out
//           | release_done                              |
//  config   | cfg_we, cfg_index, cfg_data (write only)  | in
//
// A note command leaves the block ready for the next word. A sample word
// runs through up to three multiply passes (one gain bit per cycle), each
// pass that forms a gain ratio followed by a normalize step and a restoring
// divide, and ends in a final state. Sustain needs the fewest passes and
// release the most; a release that has run out needs none.
// Reset restores the default lengths and full sustain and leaves the note held
// at position one. A stalled output holds its word; the next word is taken
// while it waits and finishes into the final state, which holds until the
// output register is free.
module adsr_envelope_gain #(
  parameter int COUNT_BITS  = 20,
  parameter int SAMPLE_BITS = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [1:0]                    cfg_index_i,
  input  logic [((COUNT_BITS > adsr_pkg::GAIN_BITS) ? COUNT_BITS :
                 adsr_pkg::GAIN_BITS)-1:0] cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [1:0]                    cmd_i,
  input  logic signed [SAMPLE_BITS-1:0] audio_in_i,
  input  logic [COUNT_BITS:0]           start_position_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic signed [SAMPLE_BITS-1:0] audio_out_o,
  output logic [1:0]                    stage_o,
  output logic                          release_done_o
);
  import adsr_pkg::*;

  localparam int CB = COUNT_BITS;
  localparam int SB = SAMPLE_BITS;
  // Multiplicand width: an unsigned count or a signed sample, plus a sign bit.
  localparam int XW = ((CB > SB) ? CB : SB) + 1;
  localparam int PW = XW + 1 + GAIN_BITS;
  localparam int QW = PW - FRAC_BITS;

  // Configuration registers.
  logic [CB-1:0]        attack_len_q, decay_len_q, release_len_q;
  logic [GAIN_BITS-1:0] sustain_q;

  // Envelope state.
  logic [CB:0]   pos_q, pos_d;
  logic [CB-1:0] rp_q, rp_d;
  logic          released_q, released_d;
  stage_e        frozen_q, frozen_d;
  logic          done_q, done_d;

  // Sequencer.
  state_e               st_q, st_d;
  pass_e                pass_q, pass_d;
  logic [STEP_BITS-1:0] cnt_q, cnt_d;

  // Datapath.
  logic [XW-1:0]        x_q, x_d;
  logic [GAIN_BITS-1:0] y_q, y_d;
  logic [XW:0]          hi_q, hi_d;
  logic [GAIN_BITS-1:0] lo_q, lo_d;
  logic [CB:0]          rem_q, rem_d;
  logic [CB-1:0]        den_q, den_d;
  logic                 dec_q, dec_d;
  logic [SB-1:0]        smp_q, smp_d;
  logic                 rel_q, rel_d;
  logic [CB-1:0]        rk_q, rk_d;
  logic                 zero_q, zero_d;
  stage_e               res_stage_q, res_stage_d;
  logic                 res_done_q, res_done_d;

  // Output register.
  logic          out_valid_q, out_valid_d;
  logic [SB-1:0] out_audio_q, out_audio_d;
  stage_e        out_stage_q, out_stage_d;
  logic          out_done_q, out_done_d;

  // Combinational helpers.
  logic [CB-1:0]        a_eff_w, d_eff_w, r_eff_w;
  logic [GAIN_BITS-1:0] l_eff_w;
  logic                 acc_w, acc_smp_w;
  logic [CB:0]          plast_w, ad_sum_w, p_w, p_off_w;
  stage_e               held_stage_w, s_w;
  logic                 p_gt_a_w;
  logic [CB-1:0]        k_w, rk_w, rp_inc_w;
  logic                 rel_zero_w, done_next_w;
  logic                 imm_gain_w;
  logic [GAIN_BITS-1:0] imm_gv_w, gv_w, quo_w;
  logic                 last_w, div_done_w, gain_rdy_w, rel_w, zero_now_w;
  logic [SB-1:0]        smp_w;
  logic [CB+1:0]        div_t_w, div_m_w, div_diff_w;
  logic                 div_ge_w;
  logic [XW+1:0]        mul_add_w, mul_sum_w;
  logic [PW-1:0]        prod_w;
  logic [CB+16:0]       norm_w;
  logic signed [PW-1:0] rnd_w;
  logic [QW-1:0]        qv_w;
  logic                 ovf_w;
  logic [SB-1:0]        sat_w;
  logic                 out_free_w;

  assign in_ready_o     = (st_q == ST_IDLE);
  assign out_valid_o    = out_valid_q;
  assign audio_out_o    = out_audio_q;
  assign stage_o        = out_stage_q;
  assign release_done_o = out_done_q;

  // Effective configuration: zero lengths act as one, sustain caps at 1.0.
  always_comb begin
    a_eff_w = (attack_len_q == '0) ? CB'(1) : attack_len_q;
    d_eff_w = (decay_len_q == '0) ? CB'(1) : decay_len_q;
    r_eff_w = (release_len_q == '0) ? CB'(1) : release_len_q;
    l_eff_w = (sustain_q > GAIN_ONE) ? GAIN_ONE : sustain_q;
  end

  // Stage, position and gain setup for the sample word being accepted.
  always_comb begin
    acc_w     = in_valid_i && in_ready_o;
    acc_smp_w = acc_w && (cmd_i == CMD_SAMPLE);
    plast_w   = (pos_q != '0) ? (pos_q - 1'b1) : '0;
    ad_sum_w  = {1'b0, a_eff_w} + {1'b0, d_eff_w};
    if (pos_q <= {1'b0, a_eff_w}) begin
      held_stage_w = STAGE_ATTACK;
    end else if (pos_q <= ad_sum_w) begin
      held_stage_w = STAGE_DECAY;
    end else begin
      held_stage_w = STAGE_SUSTAIN;
    end
    p_w      = released_q ? plast_w : pos_q;
    s_w      = released_q ? frozen_q : held_stage_w;
    p_gt_a_w = (p_w > {1'b0, a_eff_w});
    p_off_w  = p_w - {1'b0, a_eff_w};
    if (!p_gt_a_w) begin
      k_w = '0;
    end else if (p_off_w > {1'b0, d_eff_w}) begin
      k_w = d_eff_w;
    end else begin
      k_w = p_off_w[CB-1:0];
    end
    rel_zero_w  = released_q && (rp_q >= r_eff_w);
    rp_inc_w    = (rp_q != '1) ? (rp_q + 1'b1) : rp_q;
    done_next_w = done_q || (rp_inc_w >= r_eff_w);
    // Gains that need no division: sustain, and attack past its length.
    case (s_w)
      STAGE_ATTACK: begin
        imm_gain_w = p_gt_a_w;
        imm_gv_w   = GAIN_ONE;
      end
      STAGE_DECAY: begin
        imm_gain_w = 1'b0;
        imm_gv_w   = GAIN_ONE;
      end
      default: begin
        imm_gain_w = 1'b1;
        imm_gv_w   = l_eff_w;
      end
    endcase
  end

  // Multiplier and divider steps, and the gain hand-off between passes.
  always_comb begin
    mul_add_w  = y_q[0] ? {{2{x_q[XW-1]}}, x_q} : '0;
    mul_sum_w  = {hi_q[XW], hi_q} + mul_add_w;
    prod_w     = {hi_q, lo_q};
    norm_w     = {prod_w[CB+15:0], 1'b0} + (CB+17)'(den_q);
    div_t_w    = {rem_q, lo_q[GAIN_BITS-1]};
    div_m_w    = {1'b0, den_q, 1'b0};
    div_ge_w   = (div_t_w >= div_m_w);
    div_diff_w = div_t_w - div_m_w;
    quo_w      = {lo_q[GAIN_BITS-2:0], div_ge_w};
    last_w     = (cnt_q == '0);
    div_done_w = (st_q == ST_DIV) && last_w;
    gain_rdy_w = (acc_smp_w && !rel_zero_w && imm_gain_w) ||
                 (div_done_w && (pass_q == PASS_GAIN));
    if (acc_smp_w) begin
      gv_w = imm_gv_w;
    end else if (dec_q) begin
      gv_w = GAIN_ONE - quo_w;
    end else begin
      gv_w = quo_w;
    end
    rel_w      = acc_smp_w ? released_q : rel_q;
    smp_w      = acc_smp_w ? audio_in_i : smp_q;
    rk_w       = acc_smp_w ? (r_eff_w - rp_q) : rk_q;
    // A negative sample with a nonzero release gain gives silence.
    zero_now_w = gain_rdy_w && rel_w && smp_w[SB-1] && (gv_w != '0);
  end

  // Rounding and saturation of the scaled sample.
  always_comb begin
    rnd_w  = $signed(prod_w) + $signed(PW'(ROUND_HALF));
    qv_w   = rnd_w[PW-1:FRAC_BITS];
    ovf_w  = !(&qv_w[QW-1:SB-1]) && (|qv_w[QW-1:SB-1]);
    if (!ovf_w) begin
      sat_w = qv_w[SB-1:0];
    end else if (qv_w[QW-1]) begin
      sat_w = {1'b1, {(SB-1){1'b0}}};
    end else begin
      sat_w = {1'b0, {(SB-1){1'b1}}};
    end
    out_free_w = !out_valid_q || out_ready_i;
  end

  // Next state.
  always_comb begin
    st_d = st_q;
    unique case (st_q)
      ST_IDLE: begin
        if (acc_smp_w) begin
          if (rel_zero_w || zero_now_w) begin
            st_d = ST_FIN;
          end else begin
            st_d = ST_MUL;
          end
        end
      end
      ST_MUL: begin
        if (last_w) begin
          st_d = (pass_q == PASS_SMP) ? ST_FIN : ST_NORM;
        end
      end
      ST_NORM: begin
        st_d = ST_DIV;
      end
      ST_DIV: begin
        if (last_w) begin
          st_d = zero_now_w ? ST_FIN : ST_MUL;
        end
      end
      ST_FIN: begin
        if (out_free_w) begin
          st_d = ST_IDLE;
        end
      end
    endcase
  end

  // Datapath and envelope state updates.
  always_comb begin
    pos_d       = pos_q;
    rp_d        = rp_q;
    released_d  = released_q;
    frozen_d    = frozen_q;
    done_d      = done_q;
    pass_d      = pass_q;
    cnt_d       = cnt_q;
    x_d         = x_q;
    y_d         = y_q;
    hi_d        = hi_q;
    lo_d        = lo_q;
    rem_d       = rem_q;
    den_d       = den_q;
    dec_d       = dec_q;
    smp_d       = smp_q;
    rel_d       = rel_q;
    rk_d        = rk_q;
    zero_d      = zero_q;
    res_stage_d = res_stage_q;
    res_done_d  = res_done_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_audio_d = out_audio_q;
    out_stage_d = out_stage_q;
    out_done_d  = out_done_q;

    // Accepted word: note commands act at once, samples start the work.
    if (acc_w) begin
      case (cmd_i)
        CMD_SAMPLE: begin
          smp_d  = audio_in_i;
          rel_d  = released_q;
          rk_d   = r_eff_w - rp_q;
          zero_d = rel_zero_w;
          if (released_q) begin
            res_stage_d = STAGE_RELEASE;
            rp_d        = rp_inc_w;
            done_d      = done_next_w;
            res_done_d  = done_next_w;
          end else begin
            res_stage_d = held_stage_w;
            res_done_d  = done_q;
            frozen_d    = held_stage_w;
            pos_d       = (pos_q != '1) ? (pos_q + 1'b1) : pos_q;
          end
          // Attack or decay gain needs one multiply-divide pass.
          if (!rel_zero_w && !imm_gain_w) begin
            pass_d = PASS_GAIN;
            hi_d   = '0;
            cnt_d  = '1;
            if (s_w == STAGE_DECAY) begin
              x_d   = {{(XW-CB){1'b0}}, k_w};
              y_d   = GAIN_ONE - l_eff_w;
              den_d = d_eff_w;
              dec_d = 1'b1;
            end else begin
              x_d   = {{(XW-CB){1'b0}}, p_w[CB-1:0]};
              y_d   = GAIN_ONE;
              den_d = a_eff_w;
              dec_d = 1'b0;
            end
          end
        end
        CMD_NOTE_ON: begin
          pos_d      = start_position_i;
          released_d = 1'b0;
          done_d     = 1'b0;
          rp_d       = CB'(1);
        end
        CMD_NOTE_OFF: begin
          released_d = 1'b1;
        end
        default: begin
        end
      endcase
    end

    // Envelope gain known: flag a silent word, ramp the gain down in release, else scale the sample.
    if (gain_rdy_w) begin
      if (zero_now_w) begin
        zero_d = 1'b1;
      end else if (rel_w) begin
        pass_d = PASS_REL;
        x_d    = {{(XW-CB){1'b0}}, rk_w};
        y_d    = gv_w;
        den_d  = r_eff_w;
        dec_d  = 1'b0;
        hi_d   = '0;
        cnt_d  = '1;
      end else begin
        pass_d = PASS_SMP;
        x_d    = {{(XW-SB){smp_w[SB-1]}}, smp_w};
        y_d    = gv_w;
        hi_d   = '0;
        cnt_d  = '1;
      end
    end

    case (st_q)
      // Shift-add multiply, one multiplier bit per cycle, LSB first.
      ST_MUL: begin
        hi_d  = mul_sum_w[XW+1:1];
        lo_d  = {mul_sum_w[0], lo_q[GAIN_BITS-1:1]};
        y_d   = y_q >> 1;
        cnt_d = cnt_q - 1'b1;
      end
      // Form 2*P + D; the upper part is already below the divisor 2*D.
      ST_NORM: begin
        rem_d = norm_w[CB+16:GAIN_BITS];
        lo_d  = norm_w[GAIN_BITS-1:0];
        cnt_d = '1;
      end
      // Restoring divide, one quotient bit per cycle.
      ST_DIV: begin
        rem_d = div_ge_w ? div_diff_w[CB:0] : div_t_w[CB:0];
        lo_d  = quo_w;
        cnt_d = cnt_q - 1'b1;
        if (last_w && (pass_q == PASS_REL)) begin
          pass_d = PASS_SMP;
          x_d    = {{(XW-SB){smp_q[SB-1]}}, smp_q};
          y_d    = quo_w;
          hi_d   = '0;
          cnt_d  = '1;
        end
      end
      // Hand the finished word to the output register.
      ST_FIN: begin
        if (out_free_w) begin
          out_valid_d = 1'b1;
          out_audio_d = zero_q ? '0 : sat_w;
          out_stage_d = res_stage_q;
          out_done_d  = res_done_q;
        end
      end
      default: begin
      end
    endcase
  end

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      attack_len_q  <= CB'(DEFAULT_LEN);
      decay_len_q   <= CB'(DEFAULT_LEN);
      sustain_q     <= GAIN_ONE;
      release_len_q <= CB'(DEFAULT_LEN);
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        REG_ATTACK_LEN:  attack_len_q  <= cfg_data_i[CB-1:0];
        REG_DECAY_LEN:   decay_len_q   <= cfg_data_i[CB-1:0];
        REG_SUSTAIN_LVL: sustain_q     <= cfg_data_i[GAIN_BITS-1:0];
        REG_RELEASE_LEN: release_len_q <= cfg_data_i[CB-1:0];
      endcase
    end
  end

  // Control and envelope state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= ST_IDLE;
      pass_q      <= PASS_GAIN;
      cnt_q       <= '0;
      pos_q       <= (CB+1)'(1);
      rp_q        <= CB'(1);
      released_q  <= 1'b0;
      frozen_q    <= STAGE_ATTACK;
      done_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      st_q        <= st_d;
      pass_q      <= pass_d;
      cnt_q       <= cnt_d;
      pos_q       <= pos_d;
      rp_q        <= rp_d;
      released_q  <= released_d;
      frozen_q    <= frozen_d;
      done_q      <= done_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Datapath and output payload.
  always_ff @(posedge clk_i) begin
    x_q         <= x_d;
    y_q         <= y_d;
    hi_q        <= hi_d;
    lo_q        <= lo_d;
    rem_q       <= rem_d;
    den_q       <= den_d;
    dec_q       <= dec_d;
    smp_q       <= smp_d;
    rel_q       <= rel_d;
    rk_q        <= rk_d;
    zero_q      <= zero_d;
    res_stage_q <= res_stage_d;
    res_done_q  <= res_done_d;
    out_audio_q <= out_audio_d;
    out_stage_q <= out_stage_d;
    out_done_q  <= out_done_d;
  end

endmodule
